// ===== rtl/cau_pkg.sv =====
// shared types for the complex arithmetic unit
// operation codes and the control bundle that travels down the pipeline
// no dependencies
package cau_pkg;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef struct packed {
		logic is_div;
		logic dz;
		logic ovr_r;
		logic ovr_i;
		logic neg_r;
		logic neg_i;
		logic sat;
	} ctl_t;

endpackage

// ===== rtl/cau_front.sv =====
// front end: operand products and sums (stage 1), then combine, sign split and
// finishing of add, subtract and multiply results (stage 2)
// depends on cau_pkg
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  logic [1:0]                    kind,
	input  logic signed [DATA_WIDTH-1:0]  a_real,
	input  logic signed [DATA_WIDTH-1:0]  a_imag,
	input  logic signed [DATA_WIDTH-1:0]  b_real,
	input  logic signed [DATA_WIDTH-1:0]  b_imag,
	output ctl_t                          ctl_s2,
	output logic [2*DATA_WIDTH-1:0]       mag_r_s2,
	output logic [2*DATA_WIDTH-1:0]       mag_i_s2,
	output logic [2*DATA_WIDTH-1:0]       den_s2,
	output logic [DATA_WIDTH-1:0]         res_r_s2,
	output logic [DATA_WIDTH-1:0]         res_i_s2
);
	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * DATA_WIDTH;
	localparam logic [PW-1:0] HALF_M = PW'(1) << (W - 1);

	kind_t                 kind_s1;
	logic signed [PW-1:0]  p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, sq_r_s1, sq_i_s1;
	logic signed [W:0]     sum_r_s1, sum_i_s1;

	logic signed [PW:0]    lin_r, lin_i;
	logic [PW:0]           abs_r, abs_i;
	logic [PW-1:0]         sh_r, sh_i, lim_r, lim_i, cm_r, cm_i;
	logic                  neg_r, neg_i, nz_r, nz_i, sat_r, sat_i, is_div;
	logic [PW-1:0]         den;

	// stage 1: products and the linear sums
	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1  <= kind_t'(kind);
			p_rr_s1  <= PW'(a_real) * PW'(b_real);
			p_ii_s1  <= PW'(a_imag) * PW'(b_imag);
			p_ir_s1  <= PW'(a_imag) * PW'(b_real);
			p_ri_s1  <= PW'(a_real) * PW'(b_imag);
			sq_r_s1  <= PW'(b_real) * PW'(b_real);
			sq_i_s1  <= PW'(b_imag) * PW'(b_imag);
			if (kind_t'(kind) == KIND_SUB) begin
				sum_r_s1 <= (W+1)'(a_real) - (W+1)'(b_real);
				sum_i_s1 <= (W+1)'(a_imag) - (W+1)'(b_imag);
			end else begin
				sum_r_s1 <= (W+1)'(a_real) + (W+1)'(b_real);
				sum_i_s1 <= (W+1)'(a_imag) + (W+1)'(b_imag);
			end
		end
	end

	// combine products per operation
	always_comb begin
		case (kind_s1)
			KIND_ADD, KIND_SUB: begin
				lin_r = (PW+1)'(sum_r_s1);
				lin_i = (PW+1)'(sum_i_s1);
			end
			KIND_MUL: begin
				lin_r = (PW+1)'(p_rr_s1) - (PW+1)'(p_ii_s1);
				lin_i = (PW+1)'(p_ir_s1) + (PW+1)'(p_ri_s1);
			end
			default: begin
				lin_r = (PW+1)'(p_rr_s1) + (PW+1)'(p_ii_s1);
				lin_i = (PW+1)'(p_ir_s1) - (PW+1)'(p_ri_s1);
			end
		endcase
	end

	// sign and magnitude, truncate toward zero, clip
	always_comb begin
		is_div = (kind_s1 == KIND_DIV);
		neg_r  = lin_r[PW];
		neg_i  = lin_i[PW];
		abs_r  = neg_r ? $unsigned(-lin_r) : $unsigned(lin_r);
		abs_i  = neg_i ? $unsigned(-lin_i) : $unsigned(lin_i);
		sh_r   = (kind_s1 == KIND_MUL) ? (abs_r[PW-1:0] >> FRAC_BITS) : abs_r[PW-1:0];
		sh_i   = (kind_s1 == KIND_MUL) ? (abs_i[PW-1:0] >> FRAC_BITS) : abs_i[PW-1:0];
		nz_r   = neg_r && (sh_r != '0);
		nz_i   = neg_i && (sh_i != '0);
		lim_r  = nz_r ? HALF_M : HALF_M - PW'(1);
		lim_i  = nz_i ? HALF_M : HALF_M - PW'(1);
		sat_r  = sh_r > lim_r;
		sat_i  = sh_i > lim_i;
		cm_r   = sat_r ? lim_r : sh_r;
		cm_i   = sat_i ? lim_i : sh_i;
		den    = $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2.is_div <= is_div;
			ctl_s2.dz     <= is_div && (den == '0);
			ctl_s2.ovr_r  <= 1'b0;
			ctl_s2.ovr_i  <= 1'b0;
			ctl_s2.neg_r  <= neg_r;
			ctl_s2.neg_i  <= neg_i;
			ctl_s2.sat    <= (sat_r || sat_i) && !is_div;
			mag_r_s2      <= abs_r[PW-1:0];
			mag_i_s2      <= abs_i[PW-1:0];
			den_s2        <= den;
			res_r_s2      <= nz_r ? -cm_r[W-1:0] : cm_r[W-1:0];
			res_i_s2      <= nz_i ? -cm_i[W-1:0] : cm_i[W-1:0];
		end
	end

endmodule

// ===== rtl/cau_div_step.sv =====
// one restoring division step for both result lanes, registered
// depends on cau_pkg
module cau_div_step import cau_pkg::*; #(
	parameter int DW    = 41,
	parameter int MW    = 32,
	parameter int QW    = 16,
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            en,
	input  ctl_t            ctl_in,
	input  logic [MW-1:0]   den_in,
	input  logic [DW-1:0]   rem_r_in,
	input  logic [DW-1:0]   rem_i_in,
	input  logic [QW-1:0]   q_r_in,
	input  logic [QW-1:0]   q_i_in,
	input  logic [QW-1:0]   res_r_in,
	input  logic [QW-1:0]   res_i_in,
	output ctl_t            ctl_q,
	output logic [MW-1:0]   den_q,
	output logic [DW-1:0]   rem_r_q,
	output logic [DW-1:0]   rem_i_q,
	output logic [QW-1:0]   q_r_q,
	output logic [QW-1:0]   q_i_q,
	output logic [QW-1:0]   res_r_q,
	output logic [QW-1:0]   res_i_q
);
	logic [DW-1:0] dsh;
	logic          ge_r, ge_i;

	// trial subtract of the shifted divisor
	always_comb begin
		dsh  = DW'(den_in) << SHIFT;
		ge_r = rem_r_in >= dsh;
		ge_i = rem_i_in >= dsh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q   <= ctl_in;
			den_q   <= den_in;
			rem_r_q <= ge_r ? rem_r_in - dsh : rem_r_in;
			rem_i_q <= ge_i ? rem_i_in - dsh : rem_i_in;
			q_r_q   <= q_r_in | (QW'(ge_r) << SHIFT);
			q_i_q   <= q_i_in | (QW'(ge_i) << SHIFT);
			res_r_q <= res_r_in;
			res_i_q <= res_i_in;
		end
	end

endmodule

// ===== rtl/complex_arith_unit.sv =====
// complex arithmetic unit top level: front end, overflow check,
// restoring divider pipeline and output register
// depends on cau_pkg, cau_front, cau_div_step
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  kind, a_real, a_imag, b_real, b_imag
// out      from block out_valid/out_stall  res_real, res_imag, saturated, divide_by_zero
//
// one item per clock sustained unless out_stall holds the pipeline;
// DATA_WIDTH + 4 register stages for every operation (two front stages, overflow check,
// one divider step per quotient bit, output)
// the divider loop sets the depth; each divider stage holds one bit step
// reset clears only the valid bits; payload registers are not reset
// a stall holds only stages that are full and blocked, bubbles still close up
module complex_arith_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic signed [DATA_WIDTH-1:0]  a_real,
	input  logic signed [DATA_WIDTH-1:0]  a_imag,
	input  logic signed [DATA_WIDTH-1:0]  b_real,
	input  logic signed [DATA_WIDTH-1:0]  b_imag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  res_real,
	output logic signed [DATA_WIDTH-1:0]  res_imag,
	output logic                          saturated,
	output logic                          divide_by_zero
);
	localparam int W  = DATA_WIDTH;
	localparam int MW = 2 * DATA_WIDTH;
	localparam int DW = MW + DATA_WIDTH + FRAC_BITS + 1;
	localparam int NS = DATA_WIDTH + 4;
	localparam logic [W-1:0] HALF = W'(1) << (W - 1);

	logic          vld_q [NS];
	logic          rdy   [NS];

	ctl_t          ctl_s2;
	logic [MW-1:0] mag_r_s2, mag_i_s2, den_s2;
	logic [W-1:0]  res_r_s2, res_i_s2;

	ctl_t          ctl_a   [W+1];
	logic [MW-1:0] den_a   [W+1];
	logic [DW-1:0] rem_r_a [W+1];
	logic [DW-1:0] rem_i_a [W+1];
	logic [W-1:0]  q_r_a   [W+1];
	logic [W-1:0]  q_i_a   [W+1];
	logic [W-1:0]  res_r_a [W+1];
	logic [W-1:0]  res_i_a [W+1];

	logic [DW-1:0] rem0_r, rem0_i, dlim;
	ctl_t          ctl0;

	ctl_t          cf;
	logic [W-1:0]  qr, qi, lr, li, mr, mi;
	logic          nr, ni, sr, si;

	logic [W-1:0]  res_r_s4, res_i_s4;
	logic          sat_s4, dz_s4;

	// per-stage ready: a stage moves when empty or when the next moves
	always_comb begin
		rdy[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NS-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stages one and two
	cau_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.en_s1    (rdy[0]),
		.en_s2    (rdy[1]),
		.kind     (kind),
		.a_real   (a_real),
		.a_imag   (a_imag),
		.b_real   (b_real),
		.b_imag   (b_imag),
		.ctl_s2   (ctl_s2),
		.mag_r_s2 (mag_r_s2),
		.mag_i_s2 (mag_i_s2),
		.den_s2   (den_s2),
		.res_r_s2 (res_r_s2),
		.res_i_s2 (res_i_s2)
	);

	// stage three: scale numerators, flag quotients of 2^W and above
	always_comb begin
		rem0_r     = DW'(mag_r_s2) << FRAC_BITS;
		rem0_i     = DW'(mag_i_s2) << FRAC_BITS;
		dlim       = DW'(den_s2) << W;
		ctl0       = ctl_s2;
		ctl0.ovr_r = ctl_s2.is_div && (rem0_r >= dlim);
		ctl0.ovr_i = ctl_s2.is_div && (rem0_i >= dlim);
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			ctl_a[0]       <= ctl0;
			den_a[0]       <= den_s2;
			rem_r_a[0]     <= rem0_r;
			rem_i_a[0]     <= rem0_i;
			q_r_a[0]       <= '0;
			q_i_a[0]       <= '0;
			res_r_a[0]     <= res_r_s2;
			res_i_a[0]     <= res_i_s2;
		end
	end

	// divider: one quotient bit per stage, most significant first
	for (genvar j = 0; j < W; j++) begin : g_div
		cau_div_step #(
			.DW    (DW),
			.MW    (MW),
			.QW    (W),
			.SHIFT (W - 1 - j)
		) u_step (
			.clk      (clk),
			.en       (rdy[j+3]),
			.ctl_in   (ctl_a[j]),
			.den_in   (den_a[j]),
			.rem_r_in (rem_r_a[j]),
			.rem_i_in (rem_i_a[j]),
			.q_r_in   (q_r_a[j]),
			.q_i_in   (q_i_a[j]),
			.res_r_in (res_r_a[j]),
			.res_i_in (res_i_a[j]),
			.ctl_q    (ctl_a[j+1]),
			.den_q    (den_a[j+1]),
			.rem_r_q  (rem_r_a[j+1]),
			.rem_i_q  (rem_i_a[j+1]),
			.q_r_q    (q_r_a[j+1]),
			.q_i_q    (q_i_a[j+1]),
			.res_r_q  (res_r_a[j+1]),
			.res_i_q  (res_i_a[j+1])
		);
	end

	// quotient sign, clip and result select
	always_comb begin
		cf = ctl_a[W];
		qr = q_r_a[W];
		qi = q_i_a[W];
		nr = cf.neg_r && (qr != '0 || cf.ovr_r);
		ni = cf.neg_i && (qi != '0 || cf.ovr_i);
		lr = nr ? HALF : HALF - W'(1);
		li = ni ? HALF : HALF - W'(1);
		sr = cf.ovr_r || (qr > lr);
		si = cf.ovr_i || (qi > li);
		mr = sr ? lr : qr;
		mi = si ? li : qi;
	end

	// output register
	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			if (cf.dz) begin
				res_r_s4 <= '0;
				res_i_s4 <= '0;
				sat_s4   <= 1'b0;
				dz_s4    <= 1'b1;
			end else if (cf.is_div) begin
				res_r_s4 <= nr ? -mr : mr;
				res_i_s4 <= ni ? -mi : mi;
				sat_s4   <= sr || si;
				dz_s4    <= 1'b0;
			end else begin
				res_r_s4 <= res_r_a[W];
				res_i_s4 <= res_i_a[W];
				sat_s4   <= cf.sat;
				dz_s4    <= 1'b0;
			end
		end
	end

	assign res_real       = res_r_s4;
	assign res_imag       = res_i_s4;
	assign saturated      = sat_s4;
	assign divide_by_zero = dz_s4;

endmodule

// ===== verif/tb_top.sv =====
// self-checking bench for complex_arith_unit: directed extremes, then random operations
// mostly under random idling on both channels, checked against an in-bench predictor
// depends on cau_pkg and the complex_arith_unit rtl
`timescale 1ns / 1ps

module tb_top;
	import cau_pkg::*;

	typedef struct {
		logic [15:0] re;
		logic [15:0] im;
		logic        sat;
		logic        dz;
	} cplx_res_t;

	// signed value rounded toward zero after dropping the fraction bits
	function automatic longint drop_frac(longint v);
		return (v < 0) ? -((-v) >>> 8) : (v >>> 8);
	endfunction

	// clip to the 16-bit two's complement range, flagging any clipping
	function automatic logic [15:0] clip16(longint v, inout logic sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 16'h7fff;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	// quotient part: num * 2^8 / den rounded toward zero, den positive
	function automatic longint quot_part(longint num, longint den);
		longint m;
		m = ((num < 0) ? -num : num) << 8;
		m = m / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic cplx_res_t predict_cplx(kind_t k, shortint ar, shortint ai,
			shortint br, shortint bi);
		cplx_res_t r;
		longint xr, xi, den;
		r.sat = 1'b0;
		r.dz = 1'b0;
		case (k)
			KIND_ADD: begin
				xr = longint'(ar) + longint'(br);
				xi = longint'(ai) + longint'(bi);
			end
			KIND_SUB: begin
				xr = longint'(ar) - longint'(br);
				xi = longint'(ai) - longint'(bi);
			end
			KIND_MUL: begin
				xr = drop_frac(longint'(ar) * br - longint'(ai) * bi);
				xi = drop_frac(longint'(ai) * br + longint'(ar) * bi);
			end
			default: begin
				den = longint'(br) * br + longint'(bi) * bi;
				if (den == 0) begin
					r.dz = 1'b1;
					xr = 0;
					xi = 0;
				end else begin
					xr = quot_part(longint'(ar) * br + longint'(ai) * bi, den);
					xi = quot_part(longint'(ai) * br - longint'(ar) * bi, den);
				end
			end
		endcase
		r.re = clip16(xr, r.sat);
		r.im = clip16(xi, r.sat);
		return r;
	endfunction

	// expected results in transfer order, checked against the output channel
	class cplx_scoreboard;
		cplx_res_t awaited[$];
		int        errors;
		int        checked;
		int        div_zero_seen;
		int        sat_seen;

		function void note_input(kind_t k, shortint ar, shortint ai, shortint br,
				shortint bi);
			awaited.push_back(predict_cplx(k, ar, ai, br, bi));
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic [15:0] re, logic [15:0] im, logic sat, logic dz);
			cplx_res_t e;
			if (awaited.size() == 0) begin
				report("result transfer with nothing awaited");
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (dz)
				div_zero_seen++;
			if (sat)
				sat_seen++;
			if (re !== e.re)
				report($sformatf("res_real %h, wanted %h (result %0d)", re, e.re, checked));
			if (im !== e.im)
				report($sformatf("res_imag %h, wanted %h (result %0d)", im, e.im, checked));
			if (sat !== e.sat)
				report($sformatf("saturated %b, wanted %b (result %0d)", sat, e.sat, checked));
			if (dz !== e.dz)
				report($sformatf("divide_by_zero %b, wanted %b (result %0d)", dz, e.dz,
					checked));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic signed [15:0] a_real, a_imag, b_real, b_imag;
	logic        out_valid;
	logic        out_stall;
	logic signed [15:0] res_real, res_imag;
	logic        saturated;
	logic        divide_by_zero;

	cplx_scoreboard sb;
	bit quiet;
	int stall_left;

	complex_arith_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_real(res_real), .res_imag(res_imag),
		.saturated(saturated), .divide_by_zero(divide_by_zero)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(res_real, res_imag, saturated, divide_by_zero);
	end

	// operand value: often small, sometimes full range, zero or an extreme
	function automatic shortint pick_operand();
		case ($urandom_range(0, 9))
			0: return shortint'(16'h7fff - $urandom_range(0, 1));
			1: return shortint'(16'h8000 + $urandom_range(0, 1));
			2: return 0;
			3, 4, 5: return shortint'($urandom);
			default: return shortint'($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	// one input transfer, with an optional idle burst ahead of it
	task send_item(kind_t k, shortint ar, shortint ai, shortint br, shortint bi,
			bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		a_real <= ar;
		a_imag <= ai;
		b_real <= br;
		b_imag <= bi;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(k, ar, ai, br, bi);
	endtask

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", sb.awaited.size());
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		shortint ext[5];
		kind_t k;
		shortint br, bi;
		sb = new();
		quiet = 1'b0;
		stall_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = '0;
		a_real = '0;
		a_imag = '0;
		b_real = '0;
		b_imag = '0;
		ext = '{16'sh7fff, -16'sh8000, 0, 16'sh0100, -16'sh0001};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each operation over extremes, zero divisor, unit and tiny divisors
		for (int op = 0; op < 4; op++) begin
			k = kind_t'(op);
			send_item(k, ext[0], ext[1], ext[0], ext[1], 1'b0);
			send_item(k, ext[1], ext[1], ext[1], ext[0], 1'b0);
			send_item(k, ext[3], ext[4], ext[4], ext[3], 1'b0);
			send_item(k, ext[0], ext[0], ext[2], ext[2], 1'b0);
			send_item(k, ext[1], ext[0], 16'sh0001, ext[2], 1'b0);
		end
		send_item(KIND_DIV, 16'sh0300, -16'sh0280, ext[3], ext[2], 1'b0);
		send_item(KIND_MUL, -16'sh0180, 16'sh0080, 16'sh0001, -16'sh0001, 1'b0);

		// random operations
		for (int n = 0; n < 900; n++) begin
			if (n == 450) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.awaited.size() != 0)
					@(posedge clk);
			end
			if (n == 780)
				quiet = 1'b1;
			k = kind_t'($urandom_range(0, 3));
			br = pick_operand();
			bi = pick_operand();
			if (k == KIND_DIV && $urandom_range(0, 9) == 0) begin
				br = 0;
				bi = 0;
			end
			send_item(k, pick_operand(), pick_operand(), br, bi, n < 780);
		end
		in_valid <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.report("results still awaited at end");
		$display("covered %0d results over all four operations: %0d saturated, %0d zero divisors",
			sb.checked, sb.sat_seen, sb.div_zero_seen);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/complex_arith_unit.sv
verif/tb_top.sv
